@@ rtl/lvpd_pkg.sv @@
// lvpd_pkg: shared constants, register codes and control structs of the
// label volume perimeter detector
// no dependencies
package lvpd_pkg;

    localparam int LABEL_BITS = 16;
    localparam int MAX_SIZE_Y = 256;
    localparam int MAX_SIZE_Z = 256;

    // configuration register widths
    localparam int SX_BITS  = 13;
    localparam int SYZ_BITS = 9;

    // widths of the effective (clamped) sizes
    localparam int EY_BITS = $clog2(MAX_SIZE_Y + 1);
    localparam int EZ_BITS = $clog2(MAX_SIZE_Z + 1);

    // plane and row delay line storage
    localparam int PLANE_DEPTH = MAX_SIZE_Y * MAX_SIZE_Z;
    localparam int PLANE_BITS  = $clog2(PLANE_DEPTH + 1);
    localparam int ROW_AW      = (MAX_SIZE_Z > 1) ? $clog2(MAX_SIZE_Z) : 1;
    localparam int PLANE_AW    = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;

    // stream position counter, holds volume size plus window delay
    localparam int CNT_BITS = SX_BITS + PLANE_BITS + 1;

    // configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 13;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2
    } reg_idx_t;

    typedef logic [LABEL_BITS-1:0] label_t;

    // control shared by all row delay lines
    typedef struct packed {
        logic              shift;
        logic              bypass;
        logic [ROW_AW-1:0] ptr;
    } row_ctl_t;

    // control shared by the plane delay lines
    typedef struct packed {
        logic                shift;
        logic                bypass;
        logic [PLANE_AW-1:0] ptr;
    } plane_ctl_t;

endpackage

@@ rtl/lvpd_voxel_if.sv @@
// lvpd_voxel_if: input channel carrying one voxel or pad word
// depends on lvpd_pkg
interface lvpd_voxel_if;
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [lvpd_pkg::LABEL_BITS-1:0] label;

    modport source (output valid, output action, output label, input ready);
    modport sink   (input valid, input action, input label, output ready);
endinterface

@@ rtl/lvpd_result_if.sv @@
// lvpd_result_if: output channel carrying one result word
// depends on lvpd_pkg
interface lvpd_result_if;
    logic                   valid;
    logic                   ready;
    logic [lvpd_pkg::LABEL_BITS-1:0] perimeter_label;
    logic                   last;

    modport source (output valid, output perimeter_label, output last, input ready);
    modport sink   (input valid, input perimeter_label, input last, output ready);
endinterface

@@ rtl/lvpd_cfg_if.sv @@
// lvpd_cfg_if: configuration write channel, register index and data
// depends on lvpd_pkg
interface lvpd_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [lvpd_pkg::CFG_IDX_BITS-1:0]    index;
    logic [lvpd_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/lvpd_ram.sv @@
// lvpd_ram: generic single port ram, read-before-write, registered read
// no dependencies
module lvpd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // old contents come out while the new word goes in
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata     <= mem[addr];
            mem[addr] <= wdata;
        end
    end

endmodule

@@ rtl/lvpd_row_cell.sv @@
// lvpd_row_cell: three z taps of one window row and the row delay line
// that feeds the next row cell; depends on lvpd_pkg and lvpd_ram
module lvpd_row_cell (
    input  logic               clk,
    input  lvpd_pkg::row_ctl_t ctl,
    input  lvpd_pkg::label_t   base,
    output lvpd_pkg::label_t   tap_mid,
    output lvpd_pkg::label_t   tap_far,
    output lvpd_pkg::label_t   next_base
);

    lvpd_pkg::label_t mid_reg;
    lvpd_pkg::label_t far_reg;
    lvpd_pkg::label_t line_q;

    // z shift of the row window
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            mid_reg <= base;
            far_reg <= mid_reg;
        end
    end

    // row delay, one row minus one word
    lvpd_ram #(
        .WIDTH (lvpd_pkg::LABEL_BITS),
        .DEPTH (lvpd_pkg::MAX_SIZE_Z)
    ) u_line (
        .clk   (clk),
        .en    (ctl.shift),
        .addr  (ctl.ptr),
        .wdata (base),
        .rdata (line_q)
    );

    // single voxel rows need no line storage
    assign next_base = ctl.bypass ? mid_reg : line_q;
    assign tap_mid   = mid_reg;
    assign tap_far   = far_reg;

endmodule

@@ rtl/lvpd_plane_line.sv @@
// lvpd_plane_line: delay of one plane minus one word between window planes
// depends on lvpd_pkg and lvpd_ram
module lvpd_plane_line (
    input  logic                 clk,
    input  lvpd_pkg::plane_ctl_t ctl,
    input  lvpd_pkg::label_t     base,
    input  lvpd_pkg::label_t     base_mid,
    output lvpd_pkg::label_t     next_base
);

    lvpd_pkg::label_t line_q;

    lvpd_ram #(
        .WIDTH (lvpd_pkg::LABEL_BITS),
        .DEPTH (lvpd_pkg::PLANE_DEPTH)
    ) u_line (
        .clk   (clk),
        .en    (ctl.shift),
        .addr  (ctl.ptr),
        .wdata (base),
        .rdata (line_q)
    );

    // one voxel planes take the next tap of the same row
    assign next_base = ctl.bypass ? base_mid : line_q;

endmodule

@@ rtl/label_volume_perimeter_detect.sv @@
// label_volume_perimeter_detect: streaming 3x3x3 perimeter detector
// depends on lvpd_pkg, the three channel interfaces, lvpd_row_cell, lvpd_plane_line
//
// Usage
//   voxel:  valid/ready words, action 0 = voxel label, 1 = pad (flush only).
//           Labels arrive in raster order, z fastest, x slowest.
//   result: valid/ready words, perimeter_label and last (final voxel).
//   cfg:    valid/ready writes of size_x (0), size_y (1), size_z (2); always
//           ready, a write restarts the volume. Write only while idle.
//   The result for voxel k is formed when stream word k+D is taken, where
//   D = size_y*size_z + size_z + 1, and reaches result through the compare stage and output register.
//   Pad words after the last voxel push the remaining results out.
//   Throughput is one word per cycle while result does not stall: a window of nine row cells, linked by
//   row and plane delay rams, shifts once per word taken.
//   After reset and after each register write voxel.ready stays low
//   while the plane and volume products settle.
//   When the result side stalls, one finished word waits in the output
//   register and one in the compare stage; voxel.ready then drops.
module label_volume_perimeter_detect (
    input  logic         clk,
    input  logic         rst_n,
    lvpd_voxel_if.sink   voxel,
    lvpd_result_if.source result,
    lvpd_cfg_if.sink     cfg
);

    localparam int SX = lvpd_pkg::SX_BITS;
    localparam int EY = lvpd_pkg::EY_BITS;
    localparam int EZ = lvpd_pkg::EZ_BITS;
    localparam int PB = lvpd_pkg::PLANE_BITS;
    localparam int CB = lvpd_pkg::CNT_BITS;

    // configuration registers and derived sizes
    logic [SX-1:0]                 size_x_reg;
    logic [lvpd_pkg::SYZ_BITS-1:0] size_y_reg;
    logic [lvpd_pkg::SYZ_BITS-1:0] size_z_reg;
    logic [SX-1:0]                 eff_x;
    logic [EY-1:0]                 eff_y;
    logic [EZ-1:0]                 eff_z;
    logic [SX-1:0]                 xm1;
    logic [EY-1:0]                 ym1;
    logic [EZ-1:0]                 zm1;
    logic [PB-1:0]                 plane_reg;
    logic [PB-1:0]                 plane_m1_reg;
    logic [CB-1:0]                 total_reg;
    logic [CB-1:0]                 delay_reg;
    logic [1:0]                    settle_reg;

    // stream control
    logic [CB-1:0]                 in_count_reg;
    logic [SX-1:0]                 ox_reg;
    logic [EY-1:0]                 oy_reg;
    logic [EZ-1:0]                 oz_reg;
    logic [lvpd_pkg::ROW_AW-1:0]   row_ptr_reg;
    logic [lvpd_pkg::PLANE_AW-1:0] plane_ptr_reg;
    lvpd_pkg::label_t              in_reg;

    // compare stage and output register
    logic                          v1_reg;
    logic                          last1_reg;
    logic                          xlo_reg, xhi_reg, ylo_reg, yhi_reg, zlo_reg, zhi_reg;
    logic                          out_valid_reg;
    lvpd_pkg::label_t              out_label_reg;
    logic                          out_last_reg;

    logic                          cfg_acc;
    logic                          cfg_hit;
    logic                          in_acc;
    logic                          advance;
    logic                          move;
    logic [CB-1:0]                 in_next;
    logic                          due;
    logic                          out_last;
    lvpd_pkg::row_ctl_t            row_ctl;
    lvpd_pkg::plane_ctl_t          plane_ctl;
    lvpd_pkg::label_t              base_w [3][3];
    lvpd_pkg::label_t              tap [3][3][3];
    lvpd_pkg::label_t              result_label;

    // effective sizes: zero acts as one, y and z saturate at the buffer size
    always_comb
    begin
        eff_x = (size_x_reg == '0) ? SX'(1) : size_x_reg;
        if (size_y_reg == '0)
            eff_y = EY'(1);
        else if (32'(size_y_reg) > lvpd_pkg::MAX_SIZE_Y)
            eff_y = EY'(lvpd_pkg::MAX_SIZE_Y);
        else
            eff_y = EY'(size_y_reg);
        if (size_z_reg == '0)
            eff_z = EZ'(1);
        else if (32'(size_z_reg) > lvpd_pkg::MAX_SIZE_Z)
            eff_z = EZ'(lvpd_pkg::MAX_SIZE_Z);
        else
            eff_z = EZ'(size_z_reg);
    end

    assign xm1 = eff_x - SX'(1);
    assign ym1 = eff_y - EY'(1);
    assign zm1 = eff_z - EZ'(1);

    // plane and volume products, one multiplier for each product
    always_ff @(posedge clk)
    begin
        plane_reg    <= PB'(eff_y) * PB'(eff_z);
        plane_m1_reg <= plane_reg - PB'(1);
        total_reg    <= CB'(eff_x) * CB'(plane_reg);
        delay_reg    <= CB'(plane_reg) + CB'(eff_z) + CB'(1);
    end

    // handshakes
    assign cfg.ready = 1'b1;
    assign cfg_acc   = cfg.valid && cfg.ready;
    assign cfg_hit   = cfg_acc && (cfg.index == lvpd_pkg::REG_SIZE_X
                                || cfg.index == lvpd_pkg::REG_SIZE_Y
                                || cfg.index == lvpd_pkg::REG_SIZE_Z);
    assign move        = v1_reg && (!out_valid_reg || result.ready);
    assign voxel.ready = (settle_reg == 2'd0) && (!v1_reg || move);
    assign in_acc      = voxel.valid && voxel.ready;

    // pads before the volume is complete are dropped
    assign advance  = in_acc && !(voxel.action && (in_count_reg < total_reg));
    assign in_next  = in_count_reg + CB'(1);
    assign due      = in_next > delay_reg;
    assign out_last = (ox_reg == xm1) && (oy_reg == ym1) && (oz_reg == zm1);

    // configuration, counters and line pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg    <= SX'(1);
            size_y_reg    <= lvpd_pkg::SYZ_BITS'(1);
            size_z_reg    <= lvpd_pkg::SYZ_BITS'(1);
            settle_reg    <= 2'd3;
            in_count_reg  <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            oz_reg        <= '0;
            row_ptr_reg   <= '0;
            plane_ptr_reg <= '0;
        end
        else if (cfg_hit)
        begin
            unique case (lvpd_pkg::reg_idx_t'(cfg.index))
                lvpd_pkg::REG_SIZE_X: size_x_reg <= cfg.data[SX-1:0];
                lvpd_pkg::REG_SIZE_Y: size_y_reg <= cfg.data[lvpd_pkg::SYZ_BITS-1:0];
                lvpd_pkg::REG_SIZE_Z: size_z_reg <= cfg.data[lvpd_pkg::SYZ_BITS-1:0];
                default: ;
            endcase
            settle_reg    <= 2'd3;
            in_count_reg  <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            oz_reg        <= '0;
            row_ptr_reg   <= '0;
            plane_ptr_reg <= '0;
        end
        else
        begin
            if (settle_reg != 2'd0)
                settle_reg <= settle_reg - 2'd1;
            if (advance)
            begin
                // pointers wrap at the current line lengths
                if (EZ'(row_ptr_reg) + EZ'(1) >= zm1)
                    row_ptr_reg <= '0;
                else
                    row_ptr_reg <= row_ptr_reg + lvpd_pkg::ROW_AW'(1);
                if (PB'(plane_ptr_reg) + PB'(1) >= plane_m1_reg)
                    plane_ptr_reg <= '0;
                else
                    plane_ptr_reg <= plane_ptr_reg + lvpd_pkg::PLANE_AW'(1);

                if (due && out_last)
                begin
                    in_count_reg <= '0;
                    ox_reg       <= '0;
                    oy_reg       <= '0;
                    oz_reg       <= '0;
                end
                else
                begin
                    in_count_reg <= in_next;
                    if (due)
                    begin
                        if (oz_reg == zm1)
                        begin
                            oz_reg <= '0;
                            if (oy_reg == ym1)
                            begin
                                oy_reg <= '0;
                                ox_reg <= ox_reg + SX'(1);
                            end
                            else
                                oy_reg <= oy_reg + EY'(1);
                        end
                        else
                            oz_reg <= oz_reg + EZ'(1);
                    end
                end
            end
        end
    end

    // newest word of the window
    always_ff @(posedge clk)
    begin
        if (advance)
            in_reg <= voxel.label;
    end

    assign row_ctl.shift    = advance;
    assign row_ctl.bypass   = (zm1 == '0);
    assign row_ctl.ptr      = row_ptr_reg;
    assign plane_ctl.shift  = advance;
    assign plane_ctl.bypass = (plane_m1_reg == '0);
    assign plane_ctl.ptr    = plane_ptr_reg;

    // chain of row cells: index 2 is the +1 offset, the newest side
    assign base_w[2][2] = in_reg;

    for (genvar ix = 0; ix < 3; ix++)
    begin : g_x
        for (genvar iy = 0; iy < 3; iy++)
        begin : g_y
            assign tap[ix][iy][2] = base_w[ix][iy];
            if (iy > 0)
            begin : g_link
                lvpd_row_cell u_cell (
                    .clk       (clk),
                    .ctl       (row_ctl),
                    .base      (base_w[ix][iy]),
                    .tap_mid   (tap[ix][iy][1]),
                    .tap_far   (tap[ix][iy][0]),
                    .next_base (base_w[ix][iy-1])
                );
            end
            else
            begin : g_end
                lvpd_row_cell u_cell (
                    .clk       (clk),
                    .ctl       (row_ctl),
                    .base      (base_w[ix][iy]),
                    .tap_mid   (tap[ix][iy][1]),
                    .tap_far   (tap[ix][iy][0]),
                    .next_base ()
                );
            end
        end
        if (ix > 0)
        begin : g_plane
            lvpd_plane_line u_plane (
                .clk       (clk),
                .ctl       (plane_ctl),
                .base      (base_w[ix][2]),
                .base_mid  (tap[ix][2][1]),
                .next_base (base_w[ix-1][2])
            );
        end
    end

    // compare stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (advance)
            v1_reg <= due;
        else if (move)
            v1_reg <= 1'b0;
    end

    // bounds of the voxel under test
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            last1_reg <= out_last;
            xlo_reg   <= (ox_reg != '0);
            xhi_reg   <= (ox_reg != xm1);
            ylo_reg   <= (oy_reg != '0);
            yhi_reg   <= (oy_reg != ym1);
            zlo_reg   <= (oz_reg != '0);
            zhi_reg   <= (oz_reg != zm1);
        end
    end

    // compare the centre against its in-bounds neighbours
    always_comb
    begin
        logic             ok_x [3];
        logic             ok_y [3];
        logic             ok_z [3];
        logic             border;
        lvpd_pkg::label_t centre;

        ok_x[0] = xlo_reg;  ok_x[1] = 1'b1;  ok_x[2] = xhi_reg;
        ok_y[0] = ylo_reg;  ok_y[1] = 1'b1;  ok_y[2] = yhi_reg;
        ok_z[0] = zlo_reg;  ok_z[1] = 1'b1;  ok_z[2] = zhi_reg;
        centre  = tap[1][1][1];
        border  = 1'b0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                for (int k = 0; k < 3; k++)
                    if (ok_x[i] && ok_y[j] && ok_z[k] && (tap[i][j][k] != centre))
                        border = 1'b1;
        result_label = (border && centre != '0) ? centre : '0;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (move)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_label_reg <= result_label;
            out_last_reg  <= last1_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.perimeter_label = out_label_reg;
    assign result.last            = out_last_reg;

    // a register write holds off voxel words while the products settle
    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> !voxel.ready)
        else $error("voxel taken right after a register write");

    // a waiting compare word is never lost
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !move) |=> v1_reg)
        else $error("compare stage dropped a word");

    // the final result of a volume leaves the counters cleared
    a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && last1_reg) |-> (in_count_reg == '0 && ox_reg == '0 && oz_reg == '0))
        else $error("counters not cleared at end of volume");

endmodule

@@ sim/label_volume_perimeter_detect_checker.sv @@
// label_volume_perimeter_detect_checker: watches the voxel, result and cfg channels,
// predicts every result word and compares it; depends on lvpd_pkg and the channel interfaces
module label_volume_perimeter_detect_checker (
    input  logic   clk,
    input  logic   rst_n,
    lvpd_voxel_if  voxel,
    lvpd_result_if result,
    lvpd_cfg_if    cfg,
    output int     errors,
    output int     outstanding
);

    localparam int unsigned RING_DEPTH =
        2 * (lvpd_pkg::MAX_SIZE_Y * lvpd_pkg::MAX_SIZE_Z + lvpd_pkg::MAX_SIZE_Z + 1) + 1;

    typedef struct packed {
        lvpd_pkg::label_t perimeter_label;
        logic             last;
    } word_t;

    lvpd_pkg::label_t                ring [RING_DEPTH];
    int unsigned                     taken_cnt;
    int unsigned                     made_cnt;
    logic [lvpd_pkg::SX_BITS-1:0]    reg_sx;
    logic [lvpd_pkg::SYZ_BITS-1:0]   reg_sy;
    logic [lvpd_pkg::SYZ_BITS-1:0]   reg_sz;
    word_t                           expected_q[$];
    int                              err_cnt;

    function automatic int unsigned eff_size(int unsigned v, int unsigned top);
        if (v == 0)
            return 1;
        return (v > top) ? top : v;
    endfunction

    // one accepted word: store label, maybe form the result of an older voxel
    function automatic void take_word(logic act, lvpd_pkg::label_t lab);
        int unsigned      sx, sy, sz, plane, total, dly;
        int unsigned      k, x, y, z, nx, ny, nz;
        int               c;
        lvpd_pkg::label_t ctr;
        bit               border;
        word_t            w;
        sx    = eff_size(reg_sx, 8191);
        sy    = eff_size(reg_sy, lvpd_pkg::MAX_SIZE_Y);
        sz    = eff_size(reg_sz, lvpd_pkg::MAX_SIZE_Z);
        plane = sy * sz;
        total = sx * plane;
        dly   = plane + sz + 1;
        border = 0;
        if (taken_cnt < total) begin
            if (act)
                return;
            ring[taken_cnt % RING_DEPTH] = lab;
        end
        taken_cnt++;
        if (taken_cnt <= dly || made_cnt >= total)
            return;
        k   = made_cnt;
        z   = k % sz;
        y   = (k / sz) % sy;
        x   = k / plane;
        ctr = ring[k % RING_DEPTH];
        if (ctr != '0) begin
            for (int dx = -1; dx <= 1; dx++)
                for (int dy = -1; dy <= 1; dy++)
                    for (int dz = -1; dz <= 1; dz++)
                    begin
                        c  = int'(x) + dx;
                        nx = (c < 0) ? 0 : (c >= int'(sx)) ? sx - 1 : c;
                        c  = int'(y) + dy;
                        ny = (c < 0) ? 0 : (c >= int'(sy)) ? sy - 1 : c;
                        c  = int'(z) + dz;
                        nz = (c < 0) ? 0 : (c >= int'(sz)) ? sz - 1 : c;
                        if (ring[(nx * plane + ny * sz + nz) % RING_DEPTH] != ctr)
                            border = 1;
                    end
        end
        w.perimeter_label = border ? ctr : '0;
        w.last            = (k + 1 == total);
        expected_q.push_back(w);
        made_cnt++;
        if (made_cnt == total)
        begin
            taken_cnt = 0;
            made_cnt  = 0;
        end
    endfunction

    // predictor and comparison
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_cnt = 0;
            made_cnt  = 0;
            reg_sx    = 1;
            reg_sy    = 1;
            reg_sz    = 1;
            expected_q.delete();
            err_cnt   = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result word: label %h last %b",
                                 result.perimeter_label, result.last);
                end
                else
                begin
                    word_t w;
                    w = expected_q.pop_front();
                    if (w.perimeter_label !== result.perimeter_label ||
                        w.last !== result.last)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("result mismatch: expected label %h last %b, got %h %b",
                                     w.perimeter_label, w.last,
                                     result.perimeter_label, result.last);
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    lvpd_pkg::REG_SIZE_X: reg_sx = cfg.data[lvpd_pkg::SX_BITS-1:0];
                    lvpd_pkg::REG_SIZE_Y: reg_sy = cfg.data[lvpd_pkg::SYZ_BITS-1:0];
                    lvpd_pkg::REG_SIZE_Z: reg_sz = cfg.data[lvpd_pkg::SYZ_BITS-1:0];
                    default: ;
                endcase
                if (cfg.index inside {lvpd_pkg::REG_SIZE_X, lvpd_pkg::REG_SIZE_Y,
                                      lvpd_pkg::REG_SIZE_Z})
                begin
                    taken_cnt = 0;
                    made_cnt  = 0;
                end
            end
            if (voxel.valid && voxel.ready)
                take_word(voxel.action, voxel.label);
        end
        errors      <= err_cnt;
        outstanding <= expected_q.size();
    end

endmodule

@@ sim/label_volume_perimeter_detect_tb.sv @@
// label_volume_perimeter_detect_tb: clock, reset and stimulus for the perimeter
// detector; depends on lvpd_pkg, the channel interfaces and the checker module
module label_volume_perimeter_detect_tb;

    localparam logic [lvpd_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    bit   calm;
    int   hold_cycles;
    int   errors;
    int   outstanding;

    lvpd_voxel_if  voxel ();
    lvpd_result_if result ();
    lvpd_cfg_if    cfg ();

    label_volume_perimeter_detect i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .voxel  (voxel),
        .result (result),
        .cfg    (cfg)
    );

    label_volume_perimeter_detect_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .voxel       (voxel),
        .result      (result),
        .cfg         (cfg),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        result.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                result.ready <= 1'b0;
                hold_cycles--;
            end
            else
                result.ready <= calm || ($urandom_range(99) >= 31);
        end
    end

    function automatic int unsigned eff(int unsigned v, int unsigned top);
        if (v == 0)
            return 1;
        return (v > top) ? top : v;
    endfunction

    // one voxel word, with random idle cycles in front
    task automatic send_word(logic act, lvpd_pkg::label_t lab);
        while (!calm && $urandom_range(99) < 31)
        begin
            voxel.valid <= 1'b0;
            @(posedge clk);
        end
        voxel.valid  <= 1'b1;
        voxel.action <= act;
        voxel.label  <= lab;
        @(posedge clk);
        while (!voxel.ready)
            @(posedge clk);
    endtask

    // drain all results, then let the pipeline settle
    task automatic drain();
        voxel.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [lvpd_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [lvpd_pkg::CFG_DATA_BITS-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // write all three sizes, upper data bits random where unused
    task automatic set_sizes(int unsigned sx, int unsigned sy, int unsigned sz);
        write_reg(lvpd_pkg::REG_SIZE_X, 13'(sx));
        write_reg(lvpd_pkg::REG_SIZE_Y, {4'($urandom_range(15)), 9'(sy)});
        write_reg(lvpd_pkg::REG_SIZE_Z, {4'($urandom_range(15)), 9'(sz)});
    endtask

    // one whole volume of blob-like labels, stray pads, then the flush
    task automatic run_volume(int unsigned sx, int unsigned sy, int unsigned sz);
        int unsigned      ex, ey, ez, total, dly;
        lvpd_pkg::label_t pal [4];
        lvpd_pkg::label_t cur;
        ex    = eff(sx, 8191);
        ey    = eff(sy, lvpd_pkg::MAX_SIZE_Y);
        ez    = eff(sz, lvpd_pkg::MAX_SIZE_Z);
        total = ex * ey * ez;
        dly   = ey * ez + ez + 1;
        foreach (pal[i])
            pal[i] = ($urandom_range(3) == 0) ? '0
                                             : lvpd_pkg::label_t'($urandom_range(7, 1));
        cur = pal[0];
        for (int unsigned n = 0; n < total; n++)
        begin
            if ($urandom_range(29) == 0)
                send_word(1'b1, lvpd_pkg::label_t'($urandom));
            if ($urandom_range(19) == 0)
                cur = lvpd_pkg::label_t'($urandom);
            else if ($urandom_range(3) == 0)
                cur = pal[$urandom_range(3)];
            send_word(1'b0, cur);
        end
        // flush: a voxel word here is dropped and acts as a pad
        for (int unsigned n = 0; n < dly; n++)
            send_word(1'($urandom_range(1)), lvpd_pkg::label_t'($urandom));
        drain();
    endtask

    // stimulus and verdict
    initial
    begin
        int unsigned done_items;
        rst_n        = 1'b0;
        calm         = 1'b0;
        hold_cycles  = 0;
        voxel.valid  = 1'b0;
        voxel.action = 1'b0;
        voxel.label  = '0;
        cfg.valid    = 1'b0;
        cfg.index    = lvpd_pkg::REG_SIZE_X;
        cfg.data     = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single voxel volumes at reset sizes, pad before any voxel ignored
        send_word(1'b1, 16'hFFFF);
        send_word(1'b0, 16'hFFFF);
        repeat (3) send_word(1'b1, '0);
        send_word(1'b0, '0);
        repeat (3) send_word(1'b0, 16'hA5A5);
        drain();

        // 3x3x3 with a lone centre voxel inside one object filling the rest of the cube
        set_sizes(3, 3, 3);
        for (int n = 0; n < 27; n++)
            send_word(1'b0, (n == 13) ? 16'h8000 : 16'h0001);
        for (int n = 0; n < 13; n++)
            send_word(1'b1, '0);
        drain();

        // zero sizes act as one, an unused index changes nothing
        set_sizes(0, 0, 0);
        write_reg(REG_UNUSED, 13'h1FFF);
        run_volume(0, 0, 0);

        // random small volumes, one stretch without idling, one long hold-off
        done_items = 0;
        for (int v = 0; done_items < 300 || v < 6; v++)
        begin
            int unsigned sx, sy, sz;
            sx = $urandom_range(6, 1);
            sy = $urandom_range(5, 1);
            sz = $urandom_range(6, 1);
            set_sizes(sx, sy, sz);
            calm = (v == 3);
            if (v == 5)
                hold_cycles = 400;
            run_volume(sx, sy, sz);
            done_items += sx * sy * sz + sy * sz + sz + 1;
        end
        calm = 1'b0;

        // saturating y, no idling, receiver held off until the block fills
        set_sizes(1, 511, 1);
        calm        = 1'b1;
        hold_cycles = 400;
        run_volume(1, 511, 1);
        calm = 1'b0;

        repeat (20) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #(12 * 3000000);
        $display("Some tests failed");
        $finish;
    end

endmodule
